[rtl/core/amf_pkg.sv]
// amf_pkg: shared widths, constants, status codes and controller states for the
// aperf/mperf frequency average unit. No dependencies; compiled first.
`default_nettype none

package amf_pkg;

  localparam int DATA_W     = 64;
  localparam int BASE_W     = 24;
  localparam int STATUS_W   = 2;
  localparam int MAX_CPUS_D = 256;

  localparam int SHIFT_BITS = 7;
  localparam logic [DATA_W-1:0] PCT_SCALE = 64'd100;
  // (2^64 - 1) / 100
  localparam logic [DATA_W-1:0] AD_LIMIT  = 64'd184467440737095516;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_DIV_PCNT,
    ST_MUL_BASE,
    ST_FREQ_GO,
    ST_DIV_FREQ,
    ST_ACCUM,
    ST_AVG_CHK,
    ST_DIV_AVG,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[rtl/core/amf_if.sv]
// amf channel interfaces: sample input, result output and base_freq write port.
// Depends on amf_pkg for field widths.
`default_nettype none

interface amf_in_if import amf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] old_mperf;
  logic [DATA_W-1:0] old_aperf;
  logic [DATA_W-1:0] new_mperf;
  logic [DATA_W-1:0] new_aperf;
  logic              old_bad;
  logic              new_bad;
  logic              last_cpu;

  modport source (output valid, old_mperf, old_aperf, new_mperf, new_aperf,
                  old_bad, new_bad, last_cpu, input ready);
  modport sink   (input valid, old_mperf, old_aperf, new_mperf, new_aperf,
                  old_bad, new_bad, last_cpu, output ready);
endinterface

interface amf_out_if import amf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   cpu_freq;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   average_freq;
  logic                average_ok;
  logic                last;

  modport source (output valid, cpu_freq, status, average_freq, average_ok, last,
                  input ready);
  modport sink   (input valid, cpu_freq, status, average_freq, average_ok, last,
                  output ready);
endinterface

interface amf_cfg_if import amf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base_freq;

  modport source (output valid, base_freq, input ready);
  modport sink   (input valid, base_freq, output ready);
endinterface

`default_nettype wire

[rtl/core/amf_div.sv]
// amf_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on amf_pkg for the default data width.
`default_nettype none

module amf_div import amf_pkg::*; #(
  parameter int WIDTH = DATA_W
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [WIDTH-1:0] divisor,
  output logic                  done,
  output logic      [WIDTH-1:0] quotient
);

  localparam int CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // dividend bits leave quo at the top while quotient bits enter at the bottom
  assign shifted  = {rem, quo[WIDTH-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!diff[WIDTH]) begin
          rem <= diff[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b1};
        end else begin
          rem <= shifted[WIDTH-1:0];
          quo <= {quo[WIDTH-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/aperf_mperf_freq_average_unit.sv]
// aperf_mperf_freq_average_unit: per-cpu effective frequency and running average.
// Result paths: a read error or a zero mperf difference skips the arithmetic; a valid cpu takes
// two serial divides around a shift-add multiply by base_freq; the last cpu adds an average
// check, plus an average divide when any cpu was counted.
// Throughput: one sample at a time, the next taken the cycle after its result registers.
// Reset (rst, synchronous): base_freq, sum and cpu count to zero, channels idle.
`default_nettype none

module aperf_mperf_freq_average_unit import amf_pkg::*; #(
  parameter int MAX_CPUS = MAX_CPUS_D
) (
  input wire logic  clk,
  input wire logic  rst,
  amf_cfg_if.sink   cfg,
  amf_in_if.sink    sample,
  amf_out_if.source result
);

  localparam int CNT_W = $clog2(MAX_CPUS + 1);
  localparam int MUL_W = $clog2(BASE_W);

  state_t state, state_next;

  logic [BASE_W-1:0] base_freq;
  logic [DATA_W-1:0] md, ad;
  logic              bad, last;
  status_t           status;
  logic [DATA_W-1:0] freq, avg;
  logic              avg_ok;
  logic [DATA_W-1:0] mcand, acc;
  logic [BASE_W-1:0] mplier;
  logic [MUL_W-1:0]  mul_cnt;
  logic [DATA_W-1:0] freq_sum;
  logic [CNT_W-1:0]  valid_cpus;

  logic                out_valid;
  logic [DATA_W-1:0]   out_freq, out_avg;
  logic [STATUS_W-1:0] out_status;
  logic                out_avg_ok, out_last;

  logic              div_start, div_done;
  logic [DATA_W-1:0] div_dividend, div_divisor, div_quotient;
  logic              slot_free;

  assign slot_free    = !out_valid || result.ready;
  assign sample.ready = (state == ST_IDLE);
  assign cfg.ready    = 1'b1;

  assign result.valid        = out_valid;
  assign result.cpu_freq     = out_freq;
  assign result.status       = out_status;
  assign result.average_freq = out_avg;
  assign result.average_ok   = out_avg_ok;
  assign result.last         = out_last;

  amf_div #(.WIDTH(DATA_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      ST_IDLE: begin
        if (sample.valid) state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = bad ? ST_ACCUM : ST_SCALE;
      end
      ST_SCALE: begin
        if (md == '0) begin
          state_next = ST_ACCUM;
        end else begin
          // ad * 100 = (ad << 6) + (ad << 5) + (ad << 2), modulo 2^64
          div_start    = 1'b1;
          div_dividend = (ad << 6) + (ad << 5) + (ad << 2);
          div_divisor  = md;
          state_next   = ST_DIV_PCNT;
        end
      end
      ST_DIV_PCNT: begin
        if (div_done) state_next = ST_MUL_BASE;
      end
      ST_MUL_BASE: begin
        if (mul_cnt == MUL_W'(BASE_W - 1)) state_next = ST_FREQ_GO;
      end
      ST_FREQ_GO: begin
        div_start    = 1'b1;
        div_dividend = acc;
        div_divisor  = PCT_SCALE;
        state_next   = ST_DIV_FREQ;
      end
      ST_DIV_FREQ: begin
        if (div_done) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_next = last ? ST_AVG_CHK : ST_FINISH;
      end
      ST_AVG_CHK: begin
        if (valid_cpus != '0) begin
          div_start    = 1'b1;
          div_dividend = freq_sum;
          div_divisor  = DATA_W'(valid_cpus);
          state_next   = ST_DIV_AVG;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV_AVG: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      base_freq  <= '0;
      freq_sum   <= '0;
      valid_cpus <= '0;
    end else begin
      if (cfg.valid) base_freq <= cfg.base_freq;
      if (out_valid && result.ready && state != ST_FINISH) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (sample.valid) begin
            md     <= sample.new_mperf - sample.old_mperf;
            ad     <= sample.new_aperf - sample.old_aperf;
            bad    <= sample.old_bad | sample.new_bad;
            last   <= sample.last_cpu;
            status <= STATUS_OK;
            freq   <= '0;
            avg    <= '0;
            avg_ok <= 1'b0;
          end
        end
        ST_PREP: begin
          if (bad) begin
            status <= STATUS_BAD;
          end else if (ad > AD_LIMIT) begin
            md <= md >> SHIFT_BITS;
            ad <= ad >> SHIFT_BITS;
          end
        end
        ST_SCALE: begin
          if (md == '0) status <= STATUS_ZERO;
        end
        ST_DIV_PCNT: begin
          if (div_done) begin
            mcand   <= div_quotient;
            mplier  <= base_freq;
            acc     <= '0;
            mul_cnt <= '0;
          end
        end
        ST_MUL_BASE: begin
          if (mplier[0]) acc <= acc + mcand;
          mcand   <= mcand << 1;
          mplier  <= mplier >> 1;
          mul_cnt <= mul_cnt + 1'b1;
        end
        ST_DIV_FREQ: begin
          if (div_done) freq <= div_quotient;
        end
        ST_ACCUM: begin
          if (status == STATUS_OK && valid_cpus < CNT_W'(MAX_CPUS)) begin
            freq_sum   <= freq_sum + freq;
            valid_cpus <= valid_cpus + 1'b1;
          end
        end
        ST_DIV_AVG: begin
          if (div_done) begin
            avg    <= div_quotient;
            avg_ok <= 1'b1;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_freq   <= freq;
            out_status <= status;
            out_avg    <= avg;
            out_avg_ok <= avg_ok;
            out_last   <= last;
            // a new measurement starts after the last cpu
            if (last) begin
              freq_sum   <= '0;
              valid_cpus <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/amf_checker.sv]
// amf_checker: port-level assertions for aperf_mperf_freq_average_unit, with its bind.
// Depends on amf_pkg and the top level's interface ports.
`default_nettype none

module amf_checker import amf_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                sample_valid,
  input wire logic                sample_ready,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire logic [DATA_W-1:0]   result_cpu_freq,
  input wire logic [STATUS_W-1:0] result_status,
  input wire logic [DATA_W-1:0]   result_average_freq,
  input wire logic                result_average_ok,
  input wire logic                result_last
);

  // one sample in flight: no new transaction right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted while previous one in flight");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_status != STATUS_OK |-> result_cpu_freq == '0)
    else $error("flagged cpu reports nonzero frequency");

  a_avg_only_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_last |-> result_average_freq == '0 && !result_average_ok)
    else $error("average given on a cpu that is not last");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_cpu_freq)
      && $stable(result_status) && $stable(result_last))
    else $error("stalled result transaction changed");

endmodule

bind aperf_mperf_freq_average_unit amf_checker u_amf_checker (
  .clk                 (clk),
  .rst                 (rst),
  .sample_valid        (sample.valid),
  .sample_ready        (sample.ready),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_cpu_freq     (result.cpu_freq),
  .result_status       (result.status),
  .result_average_freq (result.average_freq),
  .result_average_ok   (result.average_ok),
  .result_last         (result.last)
);

`default_nettype wire
